FILE: hw/rtl/krtss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krtss_pkg
// shared types and constants for the keyed record table
// ----------------------------------------------------------------------------
package krtss_pkg;

    localparam int KEY_BITS         = 31;
    localparam int OP_BITS          = 3;
    localparam int OUT_TAG_BITS     = 16;
    localparam int ENTRY_BITS       = 7;
    localparam int DEF_CAPACITY     = 64;
    localparam int DEF_TAG_BITS     = 16;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_SORT   = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_RM_RD,
        ST_RM_CMP,
        ST_RM_SHIFT,
        ST_LK_RD,
        ST_LK_CMP,
        ST_SO_RD,
        ST_SO_CMP,
        ST_SO_PUT,
        ST_CLEAR,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start;      // latch request fields
        logic add;        // append record
        logic rm_rd;      // read entry at scan index
        logic rm_shift;   // move entry i+1 to i
        logic rm_dec;     // drop one record
        logic rm_step;    // advance scan index
        logic lk_init;    // set search bounds
        logic lk_rd;      // read mid entry
        logic lk_step;    // narrow bounds
        logic so_init;    // start insertion sort
        logic so_rd;      // read element j-1 (or pick i)
        logic so_move;    // shift j-1 to j
        logic so_put;     // place held element
        logic clear;
        logic set_found;
        logic set_drop;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic rm_end;     // scan index reached count
        logic rm_match;
        logic rm_last;    // shift index is last
        logic lk_empty;   // lo > hi
        logic lk_eq;
        logic so_done;    // i reached count
        logic so_j_zero;
        logic so_gt;      // key[j-1] > held key
        logic so_first;   // held element not yet loaded
    } t_sts;

endpackage

FILE: hw/rtl/krtss_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krtss_datapath
// record memories, indexes, counters and the result register
// ----------------------------------------------------------------------------
module krtss_datapath #(
    parameter int CAPACITY = krtss_pkg::DEF_CAPACITY,
    parameter int TAG_BITS = krtss_pkg::DEF_TAG_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  krtss_pkg::t_cmd                  i_cmd,
    output krtss_pkg::t_sts                  o_sts,
    input  logic [krtss_pkg::KEY_BITS-1:0]   i_key,
    input  logic [TAG_BITS-1:0]              i_tag,
    output logic                             o_found,
    output logic [krtss_pkg::OUT_TAG_BITS-1:0] o_found_tag,
    output logic [krtss_pkg::ENTRY_BITS-1:0] o_entries,
    output logic                             o_dropped
);
    import krtss_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KEY_BITS-1:0] r_key_mem [CAPACITY];
    logic [TAG_BITS-1:0] r_tag_mem [CAPACITY];

    logic [KEY_BITS-1:0] r_req_key;
    logic [TAG_BITS-1:0] r_req_tag;
    logic [CW-1:0]       r_count;
    logic [CW:0]         r_lo, r_hi;      // signed-ish: hi may reach -1
    logic [CW-1:0]       r_i, r_j;
    logic [KEY_BITS-1:0] r_rd_key, r_hold_key;
    logic [TAG_BITS-1:0] r_rd_tag, r_hold_tag;
    logic                r_hold_ok;
    logic                r_hold_pend;
    logic                r_lookup;
    logic                r_found, r_drop;
    logic                r_out_found, r_out_drop;
    logic [OUT_TAG_BITS-1:0] r_out_tag;
    logic [ENTRY_BITS-1:0]   r_out_entries;

    logic [CW:0]   w_mid;
    logic [AW-1:0] w_rd_addr, w_wr_addr;
    logic          w_we;
    logic [KEY_BITS-1:0] w_wr_key;
    logic [TAG_BITS-1:0] w_wr_tag;
    logic [CW-1:0] w_jm1;
    logic [CW:0]   w_sum;

    assign w_sum = r_lo + r_hi;
    assign w_mid = {1'b0, w_sum[CW:1]};
    assign w_jm1 = r_j - 1'b1;

    always_comb begin
        w_rd_addr = r_i[AW-1:0];
        if (i_cmd.lk_rd) w_rd_addr = w_mid[AW-1:0];
        if (i_cmd.rm_shift) begin
            // on a shift write fetch the entry two ahead of the one written, else entry i+1
            w_rd_addr = i_cmd.rm_step ? r_i[AW-1:0] + AW'(2) : r_i[AW-1:0] + 1'b1;
        end
        if (i_cmd.so_rd) w_rd_addr = r_hold_ok ? w_jm1[AW-1:0] : r_i[AW-1:0];
    end

    always_comb begin
        w_we = 1'b0;
        w_wr_addr = r_count[AW-1:0];
        w_wr_key = r_req_key;
        w_wr_tag = r_req_tag;
        if (i_cmd.add) begin
            w_we = 1'b1;
        end else if (i_cmd.rm_step && i_cmd.rm_shift) begin
            w_we = 1'b1;
            w_wr_addr = r_i[AW-1:0];
            w_wr_key = r_rd_key;
            w_wr_tag = r_rd_tag;
        end else if (i_cmd.so_move) begin
            w_we = 1'b1;
            w_wr_addr = r_j[AW-1:0];
            w_wr_key = r_rd_key;
            w_wr_tag = r_rd_tag;
        end else if (i_cmd.so_put) begin
            w_we = 1'b1;
            w_wr_addr = r_j[AW-1:0];
            w_wr_key = r_hold_key;
            w_wr_tag = r_hold_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_key_mem[w_wr_addr] <= w_wr_key;
            r_tag_mem[w_wr_addr] <= w_wr_tag;
        end
        r_rd_key <= r_key_mem[w_rd_addr];
        r_rd_tag <= r_tag_mem[w_rd_addr];
    end

    // shift write uses data read in the previous cycle at i+1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_found     <= 1'b0;
            r_drop      <= 1'b0;
            r_hold_ok   <= 1'b0;
            r_hold_pend <= 1'b0;
            r_lookup    <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_req_key <= i_key;
                r_req_tag <= i_tag;
                r_found   <= 1'b0;
                r_drop    <= 1'b0;
                r_i       <= i_cmd.so_init ? {{(CW-1){1'b0}}, 1'b1} : '0;
                r_lookup  <= i_cmd.lk_init;
            end
            if (i_cmd.add) r_count <= r_count + 1'b1;
            if (i_cmd.clear) r_count <= '0;
            if (i_cmd.set_found) r_found <= 1'b1;
            if (i_cmd.set_drop) r_drop <= 1'b1;
            if (i_cmd.rm_step) r_i <= r_i + 1'b1;
            if (i_cmd.rm_dec) r_count <= r_count - 1'b1;
            if (i_cmd.lk_init) begin
                r_lo <= '0;
                r_hi <= {1'b0, r_count} - 1'b1;
            end
            if (i_cmd.lk_step) begin
                if (r_rd_key < r_req_key) r_lo <= w_mid + 1'b1;
                else r_hi <= w_mid - 1'b1;
            end
            if (i_cmd.so_rd && !r_hold_ok) begin
                r_j <= r_i;
            end
            if (i_cmd.so_move) r_j <= w_jm1;
            if (i_cmd.so_put) r_i <= r_i + 1'b1;
            if (i_cmd.lk_rd) r_i <= w_mid[CW-1:0];

            // capture held element in the cycle after its read
            r_hold_pend <= i_cmd.so_rd && !r_hold_ok;
            if (i_cmd.so_init || i_cmd.so_put) begin
                r_hold_ok <= 1'b0;
            end else if (r_hold_pend) begin
                r_hold_ok <= 1'b1;
            end
            if (r_hold_pend) begin
                r_hold_key <= r_rd_key;
                r_hold_tag <= r_rd_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_found   <= 1'b0;
            r_out_drop    <= 1'b0;
            r_out_tag     <= '0;
            r_out_entries <= '0;
        end else if (i_cmd.out_load) begin
            r_out_found   <= r_found;
            r_out_drop    <= r_drop;
            r_out_tag     <= (r_found && r_lookup) ? OUT_TAG_BITS'(r_rd_tag) : '0;
            r_out_entries <= ENTRY_BITS'(r_count);
        end
    end

    assign o_sts.full      = (r_count == CW'(CAPACITY));
    assign o_sts.rm_end    = (r_i >= r_count);
    assign o_sts.rm_match  = (r_rd_key == r_req_key);
    assign o_sts.rm_last   = ((r_i + 1'b1) >= r_count);
    assign o_sts.lk_empty  = $signed(r_lo) > $signed(r_hi);
    assign o_sts.lk_eq     = (r_rd_key == r_req_key);
    assign o_sts.so_done   = (r_i >= r_count);
    assign o_sts.so_j_zero = (r_j == '0);
    assign o_sts.so_gt     = (r_rd_key > r_hold_key);
    assign o_sts.so_first  = !r_hold_ok;

    assign o_found     = r_out_found;
    assign o_found_tag = r_out_tag;
    assign o_entries   = r_out_entries;
    assign o_dropped   = r_out_drop;

endmodule

FILE: hw/rtl/krtss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krtss_ctrl
// sequencer for add, remove scan, binary search, insertion sort and clear
// ----------------------------------------------------------------------------
module krtss_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [krtss_pkg::OP_BITS-1:0] i_operation,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output krtss_pkg::t_cmd               o_cmd,
    input  krtss_pkg::t_sts               i_sts
);
    import krtss_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_hold_wait, n_hold_wait;
    logic   w_take;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_take      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_hold_wait <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_hold_wait <= n_hold_wait;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    case (i_operation)
                        OP_ADD:    n_state = ST_ADD;
                        OP_REMOVE: n_state = ST_RM_RD;
                        OP_LOOKUP: n_state = ST_LK_RD;
                        OP_SORT:   n_state = ST_SO_RD;
                        OP_CLEAR:  n_state = ST_CLEAR;
                        default:   n_state = ST_OUT;
                    endcase
                end
            end
            ST_ADD:    n_state = ST_OUT;
            ST_CLEAR:  n_state = ST_OUT;
            ST_RM_RD:  n_state = i_sts.rm_end ? ST_OUT : ST_RM_CMP;
            ST_RM_CMP: begin
                if (i_sts.rm_match) n_state = i_sts.rm_last ? ST_OUT : ST_RM_SHIFT;
                else n_state = ST_RM_RD;
            end
            ST_RM_SHIFT: n_state = i_sts.rm_last ? ST_OUT : ST_RM_SHIFT;
            ST_LK_RD:  n_state = i_sts.lk_empty ? ST_OUT : ST_LK_CMP;
            ST_LK_CMP: n_state = i_sts.lk_eq ? ST_OUT : ST_LK_RD;
            ST_SO_RD: begin
                if (i_sts.so_done) n_state = ST_OUT;
                else if (i_sts.so_first) n_state = ST_SO_RD;
                else if (r_hold_wait) n_state = ST_SO_RD;
                else if (i_sts.so_j_zero) n_state = ST_SO_PUT;
                else n_state = ST_SO_CMP;
            end
            ST_SO_CMP: n_state = i_sts.so_gt ? ST_SO_RD : ST_SO_PUT;
            ST_SO_PUT: n_state = ST_SO_RD;
            ST_OUT:    n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_hold_wait = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.start = w_take;
                if (w_take && i_operation == OP_LOOKUP) o_cmd.lk_init = 1'b1;
                if (w_take && i_operation == OP_SORT) o_cmd.so_init = 1'b1;
            end
            ST_ADD: begin
                if (i_sts.full) o_cmd.set_drop = 1'b1;
                else o_cmd.add = 1'b1;
            end
            ST_CLEAR: o_cmd.clear = 1'b1;
            ST_RM_RD: o_cmd.rm_rd = 1'b1;
            ST_RM_CMP: begin
                if (i_sts.rm_match) begin
                    o_cmd.set_found = 1'b1;
                    if (i_sts.rm_last) o_cmd.rm_dec = 1'b1;
                    else o_cmd.rm_shift = 1'b1;
                end else begin
                    o_cmd.rm_step = 1'b1;
                end
            end
            ST_RM_SHIFT: begin
                o_cmd.rm_shift = 1'b1;
                o_cmd.rm_step  = 1'b1;
                if (i_sts.rm_last) o_cmd.rm_dec = 1'b1;
            end
            ST_LK_RD: if (!i_sts.lk_empty) o_cmd.lk_rd = 1'b1;
            ST_LK_CMP: begin
                if (i_sts.lk_eq) o_cmd.set_found = 1'b1;
                else o_cmd.lk_step = 1'b1;
            end
            ST_SO_RD: begin
                if (!i_sts.so_done) begin
                    if (i_sts.so_first) begin
                        o_cmd.so_rd = 1'b1;
                        n_hold_wait = 1'b1;
                    end else if (!r_hold_wait && !i_sts.so_j_zero) begin
                        o_cmd.so_rd = 1'b1;
                    end
                end
            end
            ST_SO_CMP: if (i_sts.so_gt) o_cmd.so_move = 1'b1;
            ST_SO_PUT: o_cmd.so_put = 1'b1;
            ST_OUT: begin
                o_cmd.out_load = 1'b1;
                n_out_valid    = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

FILE: hw/rtl/keyed_record_table_search_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_table_search_sort
// record table with add, remove, binary search lookup, stable sort and clear
//
//   channel | signals                                   | direction
//   in      | i_in_valid/o_in_ready, operation key tag  | request in
//   out     | o_out_valid/i_out_ready, found.. dropped  | result out
//
// remove scans entries from the first and shifts later entries down over a
// match; lookup is a binary search; sort is insertion over the memory with
// one read and one write port, moving each element down past larger keys.
// synchronous active-low reset empties the table; memories are not cleared.
// a waiting result is held in the output register until it is accepted; a
// new request is taken only when no result waits or as it is accepted.
// ----------------------------------------------------------------------------
module keyed_record_table_search_sort #(
    parameter int CAPACITY = krtss_pkg::DEF_CAPACITY,
    parameter int TAG_BITS = krtss_pkg::DEF_TAG_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [krtss_pkg::OP_BITS-1:0]      i_operation,
    input  logic [krtss_pkg::KEY_BITS-1:0]     i_key,
    input  logic [TAG_BITS-1:0]                i_tag,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_found,
    output logic [krtss_pkg::OUT_TAG_BITS-1:0] o_found_tag,
    output logic [krtss_pkg::ENTRY_BITS-1:0]   o_entries,
    output logic                               o_dropped
);
    import krtss_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    krtss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    krtss_datapath #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_key       (i_key),
        .i_tag       (i_tag),
        .o_found     (o_found),
        .o_found_tag (o_found_tag),
        .o_entries   (o_entries),
        .o_dropped   (o_dropped)
    );

endmodule

FILE: dv/record_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_table_checker
// tracks the record table from accepted requests, predicts every result
// and compares it field by field against the result channel
// ----------------------------------------------------------------------------
module record_table_checker #(
    parameter int CAPACITY = krtss_pkg::DEF_CAPACITY
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic [krtss_pkg::OP_BITS-1:0]        i_operation,
    input  logic [krtss_pkg::KEY_BITS-1:0]       i_key,
    input  logic [krtss_pkg::DEF_TAG_BITS-1:0]   i_tag,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic                                 i_found,
    input  logic [krtss_pkg::OUT_TAG_BITS-1:0]   i_found_tag,
    input  logic [krtss_pkg::ENTRY_BITS-1:0]     i_entries,
    input  logic                                 i_dropped,
    output int                                   o_errors,
    output int                                   o_pending,
    output int                                   o_results
);
    import krtss_pkg::*;

    typedef struct packed {
        logic                    found;
        logic [OUT_TAG_BITS-1:0] found_tag;
        logic [ENTRY_BITS-1:0]   entries;
        logic                    dropped;
    } t_result;

    logic [KEY_BITS-1:0]     keys [CAPACITY];
    logic [DEF_TAG_BITS-1:0] tags [CAPACITY];
    int                      count;
    t_result                 expected_q[$];

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    function automatic t_result apply_request(input logic [OP_BITS-1:0] op,
                                              input logic [KEY_BITS-1:0] key,
                                              input logic [DEF_TAG_BITS-1:0] tag);
        t_result r;
        int lo, hi, mid, i, j;
        logic [KEY_BITS-1:0] hk;
        logic [DEF_TAG_BITS-1:0] ht;
        r = '0;
        case (op)
            OP_ADD: begin
                if (count < CAPACITY) begin
                    keys[count] = key;
                    tags[count] = tag;
                    count++;
                end else begin
                    r.dropped = 1'b1;
                end
            end
            OP_REMOVE: begin
                for (i = 0; i < count; i++) begin
                    if (keys[i] == key) begin
                        for (j = i; j + 1 < count; j++) begin
                            keys[j] = keys[j+1];
                            tags[j] = tags[j+1];
                        end
                        count--;
                        r.found = 1'b1;
                        break;
                    end
                end
            end
            OP_LOOKUP: begin
                lo = 0;
                hi = count - 1;
                while (lo <= hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (keys[mid] == key) begin
                        r.found = 1'b1;
                        r.found_tag = tags[mid];
                        break;
                    end else if (keys[mid] < key) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid - 1;
                    end
                end
            end
            OP_SORT: begin
                for (i = 1; i < count; i++) begin
                    hk = keys[i];
                    ht = tags[i];
                    j = i;
                    while (j > 0 && keys[j-1] > hk) begin
                        keys[j] = keys[j-1];
                        tags[j] = tags[j-1];
                        j--;
                    end
                    keys[j] = hk;
                    tags[j] = ht;
                end
            end
            OP_CLEAR: count = 0;
            default: ;
        endcase
        r.entries = count[ENTRY_BITS-1:0];
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_result w;
        if (!i_rst_n) begin
            count = 0;
            expected_q.delete();
            o_errors = 0;
            o_results = 0;
        end else begin
            if (i_in_valid && i_in_ready)
                expected_q = {expected_q, apply_request(i_operation, i_key, i_tag)};
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (expected_q.size() == 0) begin
                    report("unexpected result", 1, 0);
                end else begin
                    w = expected_q.pop_front();
                    if (i_found !== w.found) report("found", i_found, w.found);
                    if (i_found_tag !== w.found_tag)
                        report("found_tag", i_found_tag, w.found_tag);
                    if (i_entries !== w.entries) report("entries", i_entries, w.entries);
                    if (i_dropped !== w.dropped) report("dropped", i_dropped, w.dropped);
                end
            end
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives table requests with directed and random mixes under varying
// handshake gaps; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
    import krtss_pkg::*;

    localparam int CAP = DEF_CAPACITY;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [OP_BITS-1:0] OP_RSVD_LO = 3'd5;
    localparam logic [OP_BITS-1:0] OP_RSVD_HI = 3'd7;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [OP_BITS-1:0]        i_operation = '0;
    logic [KEY_BITS-1:0]       i_key = '0;
    logic [DEF_TAG_BITS-1:0]   i_tag = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic                      o_found;
    logic [OUT_TAG_BITS-1:0]   o_found_tag;
    logic [ENTRY_BITS-1:0]     o_entries;
    logic                      o_dropped;
    int                        errors, pending, results;
    int                        send_idle_pct, recv_idle_pct;
    int                        quiet_cycles;
    int                        sent;
    logic [KEY_BITS-1:0]       used_keys[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    keyed_record_table_search_sort dut (.*);

    record_table_checker #(.CAPACITY(CAP)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_operation(i_operation), .i_key(i_key), .i_tag(i_tag),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_found(o_found), .i_found_tag(o_found_tag),
        .i_entries(o_entries), .i_dropped(o_dropped),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(input logic [OP_BITS-1:0] op, input logic [KEY_BITS-1:0] key,
                        input logic [DEF_TAG_BITS-1:0] tag);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_key <= key;
        i_tag <= tag;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (op == OP_ADD) used_keys = {used_keys, key};
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        if (used_keys.size() > 0 && $urandom_range(3) != 0)
            return used_keys[$urandom_range(used_keys.size() - 1)];
        return $urandom_range(7) == 0 ? KEY_BITS'($urandom) : KEY_BITS'($urandom_range(40));
    endfunction

    task automatic random_phase(input int n);
        int r;
        logic [OP_BITS-1:0] op;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 40) op = OP_ADD;
            else if (r < 58) op = OP_REMOVE;
            else if (r < 85) op = OP_LOOKUP;
            else if (r < 94) op = OP_SORT;
            else if (r < 97) op = OP_CLEAR;
            else op = OP_BITS'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
            if (used_keys.size() > 200) used_keys.delete();
            send(op, pick_key(), DEF_TAG_BITS'($urandom));
            if (i == n / 2) drain();
        end
    endtask

    initial begin
        send_idle_pct = 8;
        recv_idle_pct = 56;
        sent = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty table cases, extremes, full table, unsorted lookup
        send(OP_LOOKUP, '1, '0);
        send(OP_REMOVE, '0, '0);
        send(OP_SORT, '0, '0);
        send(OP_ADD, '1, '1);
        send(OP_ADD, '0, 16'h5a5a);
        send(OP_ADD, 31'h2aaa_aaaa, 16'ha5a5);
        send(OP_ADD, '0, 16'h0001);
        send(OP_LOOKUP, '1, '0);
        send(OP_SORT, '0, '0);
        send(OP_LOOKUP, '1, '0);
        send(OP_LOOKUP, '0, '0);
        send(OP_LOOKUP, 31'd7, '0);
        send(OP_REMOVE, '0, '0);
        send(OP_REMOVE, 31'd9, '0);
        send(OP_RSVD_LO, 31'd1, 16'd1);
        send(OP_RSVD_HI, '1, '1);
        send(OP_CLEAR, '0, '0);
        for (int i = 0; i < CAP + 2; i++) send(OP_ADD, KEY_BITS'(CAP - i), DEF_TAG_BITS'(i));
        send(OP_SORT, '0, '0);
        send(OP_LOOKUP, 31'd1, '0);
        send(OP_CLEAR, '0, '0);
        drain();

        random_phase(530);
        drain();
        send_idle_pct = 56;
        recv_idle_pct = 8;
        random_phase(530);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(530);
        drain();
        repeat (50) @(posedge i_clk);

        $display("sent %0d requests covering add, remove, lookup, sort, clear and ignored codes",
                 sent);
        $display("%0d results checked, full table and random gap patterns included", results);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/krtss_pkg.sv
hw/rtl/krtss_datapath.sv
hw/rtl/krtss_ctrl.sv
hw/rtl/keyed_record_table_search_sort.sv
dv/record_table_checker.sv
dv/tb_top.sv
